FILE: sv/gdsd_pkg.sv
// Shared types, constants and date helper functions for the Gregorian date stepper.
package gdsd_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFF_W    = 17;
    localparam int COUNT_W  = 22;
    localparam int STATUS_W = 2;

    // Day number (signed, holds start day number plus offset) and year-start widths
    localparam int NUM_W = 23;
    localparam int DBY_W = 23;
    localparam int Q_W   = 8;
    localparam int BIT_W = 4;
    localparam int DBM_W = 9;

    // Stream widths and field positions
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = STATUS_W;

    localparam int SY_LSB  = 0;
    localparam int SM_LSB  = SY_LSB + YEAR_W;
    localparam int SD_LSB  = SM_LSB + MONTH_W;
    localparam int OFF_LSB = SD_LSB + DAY_W;
    localparam int OY_LSB  = OFF_LSB + OFF_W;
    localparam int OM_LSB  = OY_LSB + YEAR_W;
    localparam int OD_LSB  = OM_LSB + MONTH_W;
    localparam int CNT_LSB = SD_LSB + DAY_W;

    // Calendar limits
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX   = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [DAY_W-1:0]   DAY_MAX     = 5'd31;
    localparam logic [COUNT_W-1:0] LAST_DAYNUM = 22'd3652058;

    // x / 100 == (x * 5243) >> 19, exact for every 14-bit x
    localparam logic [12:0]      DIV100_MUL   = 13'd5243;
    localparam int               DIV100_SHIFT = 19;
    localparam logic [BIT_W-1:0] SEARCH_TOP   = 4'd13;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_LEAP_Q,
        CMD_LEAP_F,
        CMD_DBY_Q,
        CMD_DBY_S,
        CMD_DATE_S,
        CMD_ADD_OFF,
        CMD_SRCH_INIT,
        CMD_SRCH_Q,
        CMD_SRCH_C,
        CMD_MSET,
        CMD_WALK,
        CMD_SAVE_A,
        CMD_RES_ERR,
        CMD_RES_SAT,
        CMD_RES_STEP,
        CMD_RES_DIFF,
        CMD_OUT_LOAD
    } cmd_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic op;
        logic date_ok;
        logic out_of_range;
        logic last_bit;
        logic walk_done;
    } dp_status_t;

    // Quotient by 100 through one reciprocal multiply
    function automatic logic [Q_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [YEAR_W+12:0] p;
        p = {13'd0, x} * {{YEAR_W{1'b0}}, DIV100_MUL};
        return p[DIV100_SHIFT +: Q_W];
    endfunction

    // Leap year from the year and its quotient by 100
    function automatic logic is_leap(input logic [YEAR_W-1:0] y, input logic [Q_W-1:0] q);
        logic [YEAR_W:0] hund;
        hund = (YEAR_W+1)'(q) * (YEAR_W+1)'(100);
        return (y[1:0] == 2'b00) && ((hund != {1'b0, y}) || (q[1:0] == 2'b00));
    endfunction

    // Days from 0001-01-01 to the start of year k+1, with q = k / 100
    function automatic logic [DBY_W-1:0] dby(input logic [YEAR_W-1:0] k,
                                             input logic [Q_W-1:0] q);
        logic [DBY_W-1:0] s;
        s = DBY_W'(k) * DBY_W'(365) + DBY_W'(k >> 2) - DBY_W'(q) + DBY_W'(q >> 2);
        return s;
    endfunction

    // Month length; month must be 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = DAY_MAX;
        endcase
        return len;
    endfunction

    // Days before the first of month m in a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/gdsd_dp.sv
// Datapath: item registers, shared divide-by-100 unit, day number arithmetic, result registers.
module gdsd_dp (
    input  logic                           aclk,
    input  gdsd_pkg::cmd_t                 cmd,
    input  logic [gdsd_pkg::S_TDATA_W-1:0] s_tdata,  // start_year, start_month, start_day,
                                                     // offset_days, other_year, other_month,
                                                     // other_day, zero pad
    input  logic [gdsd_pkg::S_TUSER_W-1:0] s_tuser,  // operation
    output gdsd_pkg::dp_status_t           sts,
    output logic [gdsd_pkg::M_TDATA_W-1:0] m_tdata,  // result_year, result_month, result_day,
                                                     // day_count, zero pad
    output logic [gdsd_pkg::M_TUSER_W-1:0] m_tuser   // status
);

    // Captured item
    logic                                op_reg;
    logic [gdsd_pkg::YEAR_W-1:0]         sy_reg, oy_reg;
    logic [gdsd_pkg::MONTH_W-1:0]        sm_reg, om_reg;
    logic [gdsd_pkg::DAY_W-1:0]          sd_reg, od_reg;
    logic signed [gdsd_pkg::OFF_W-1:0]   off_reg;

    // Working date and arithmetic state
    logic [gdsd_pkg::YEAR_W-1:0]         cur_y_reg;
    logic [gdsd_pkg::MONTH_W-1:0]        cur_m_reg;
    logic [gdsd_pkg::DAY_W-1:0]          cur_d_reg;
    logic [gdsd_pkg::Q_W-1:0]            q_reg;
    logic                                leap_reg;
    logic signed [gdsd_pkg::NUM_W-1:0]   n_reg;
    logic [gdsd_pkg::COUNT_W-1:0]        a_reg;
    logic [gdsd_pkg::YEAR_W-1:0]         yy_reg;
    logic [gdsd_pkg::BIT_W-1:0]          bit_reg;
    logic [gdsd_pkg::DBY_W-1:0]          dbyacc_reg;

    // Staged result and output registers
    logic [gdsd_pkg::YEAR_W-1:0]         res_y_reg, out_y_reg;
    logic [gdsd_pkg::MONTH_W-1:0]        res_m_reg, out_m_reg;
    logic [gdsd_pkg::DAY_W-1:0]          res_d_reg, out_d_reg;
    logic [gdsd_pkg::COUNT_W-1:0]        res_cnt_reg, out_cnt_reg;
    gdsd_pkg::status_t                   res_st_reg, out_st_reg;

    logic [gdsd_pkg::YEAR_W-1:0]         trial;
    logic [gdsd_pkg::YEAR_W-1:0]         div_opnd;
    logic [gdsd_pkg::YEAR_W-1:0]         dby_k;
    logic [gdsd_pkg::DBY_W-1:0]          dby_val;
    logic [gdsd_pkg::DAY_W-1:0]          mlen;
    logic [gdsd_pkg::NUM_W-1:0]          mlen_ext;
    logic                                leap_adj;
    logic [gdsd_pkg::COUNT_W-1:0]        n_low;

    // Year search candidate: current year with the bit under test set
    assign trial = yy_reg | (gdsd_pkg::YEAR_W'(1) << bit_reg);

    // Operand of the shared divide-by-100 multiplier
    always_comb begin
        case (cmd)
            gdsd_pkg::CMD_DBY_Q:  div_opnd = cur_y_reg - gdsd_pkg::YEAR_W'(1);
            gdsd_pkg::CMD_SRCH_Q: div_opnd = trial - gdsd_pkg::YEAR_W'(1);
            default:              div_opnd = cur_y_reg;
        endcase
    end

    // Start-of-year day number, for the working year or the search candidate
    assign dby_k    = (cmd == gdsd_pkg::CMD_SRCH_C) ? trial - gdsd_pkg::YEAR_W'(1)
                                                    : cur_y_reg - gdsd_pkg::YEAR_W'(1);
    assign dby_val  = gdsd_pkg::dby(dby_k, q_reg);
    assign mlen     = gdsd_pkg::month_len(cur_m_reg, leap_reg);
    assign mlen_ext = gdsd_pkg::NUM_W'(mlen);
    assign leap_adj = leap_reg && (cur_m_reg > gdsd_pkg::MONTH_FEB);
    assign n_low    = n_reg[gdsd_pkg::COUNT_W-1:0];

    // Flags for the controller
    always_comb begin
        sts.op           = op_reg;
        sts.date_ok      = (cur_y_reg != '0) && (cur_y_reg <= gdsd_pkg::YEAR_MAX) &&
                           (cur_m_reg != '0) && (cur_m_reg <= gdsd_pkg::MONTH_MAX) &&
                           (cur_d_reg != '0) && (cur_d_reg <= mlen);
        sts.out_of_range = n_reg[gdsd_pkg::NUM_W-1] ||
                           (n_reg[gdsd_pkg::NUM_W-2:0] > (gdsd_pkg::NUM_W-1)'(gdsd_pkg::LAST_DAYNUM));
        sts.last_bit     = (bit_reg == '0);
        sts.walk_done    = !((cur_m_reg < gdsd_pkg::MONTH_MAX) && ($unsigned(n_reg) >= mlen_ext));
    end

    // Command execution
    always_ff @(posedge aclk) begin
        case (cmd)
            gdsd_pkg::CMD_LOAD: begin
                op_reg    <= s_tuser[0];
                sy_reg    <= s_tdata[gdsd_pkg::SY_LSB  +: gdsd_pkg::YEAR_W];
                sm_reg    <= s_tdata[gdsd_pkg::SM_LSB  +: gdsd_pkg::MONTH_W];
                sd_reg    <= s_tdata[gdsd_pkg::SD_LSB  +: gdsd_pkg::DAY_W];
                off_reg   <= s_tdata[gdsd_pkg::OFF_LSB +: gdsd_pkg::OFF_W];
                oy_reg    <= s_tdata[gdsd_pkg::OY_LSB  +: gdsd_pkg::YEAR_W];
                om_reg    <= s_tdata[gdsd_pkg::OM_LSB  +: gdsd_pkg::MONTH_W];
                od_reg    <= s_tdata[gdsd_pkg::OD_LSB  +: gdsd_pkg::DAY_W];
                cur_y_reg <= s_tdata[gdsd_pkg::SY_LSB  +: gdsd_pkg::YEAR_W];
                cur_m_reg <= s_tdata[gdsd_pkg::SM_LSB  +: gdsd_pkg::MONTH_W];
                cur_d_reg <= s_tdata[gdsd_pkg::SD_LSB  +: gdsd_pkg::DAY_W];
            end
            gdsd_pkg::CMD_LEAP_Q, gdsd_pkg::CMD_DBY_Q, gdsd_pkg::CMD_SRCH_Q: begin
                q_reg <= gdsd_pkg::div100(div_opnd);
            end
            gdsd_pkg::CMD_LEAP_F: begin
                leap_reg <= gdsd_pkg::is_leap(cur_y_reg, q_reg);
            end
            gdsd_pkg::CMD_DBY_S: begin
                n_reg <= $signed(dby_val);
            end
            gdsd_pkg::CMD_DATE_S: begin
                n_reg <= n_reg + gdsd_pkg::NUM_W'(gdsd_pkg::days_before_month(cur_m_reg))
                       + gdsd_pkg::NUM_W'(leap_adj) + gdsd_pkg::NUM_W'(cur_d_reg)
                       - gdsd_pkg::NUM_W'(1);
            end
            gdsd_pkg::CMD_ADD_OFF: begin
                n_reg <= n_reg + gdsd_pkg::NUM_W'(off_reg);
            end
            gdsd_pkg::CMD_SRCH_INIT: begin
                yy_reg  <= '0;
                bit_reg <= gdsd_pkg::SEARCH_TOP;
            end
            gdsd_pkg::CMD_SRCH_C: begin
                // keep the bit when that year still starts on or before the day number
                if ((trial <= gdsd_pkg::YEAR_MAX) && (dby_val <= $unsigned(n_reg))) begin
                    yy_reg     <= trial;
                    dbyacc_reg <= dby_val;
                end
                bit_reg <= bit_reg - gdsd_pkg::BIT_W'(1);
            end
            gdsd_pkg::CMD_MSET: begin
                n_reg     <= n_reg - $signed(dbyacc_reg);
                cur_y_reg <= yy_reg;
                cur_m_reg <= gdsd_pkg::MONTH_W'(1);
            end
            gdsd_pkg::CMD_WALK: begin
                n_reg     <= n_reg - $signed(mlen_ext);
                cur_m_reg <= cur_m_reg + gdsd_pkg::MONTH_W'(1);
            end
            gdsd_pkg::CMD_SAVE_A: begin
                a_reg     <= n_low;
                cur_y_reg <= oy_reg;
                cur_m_reg <= om_reg;
                cur_d_reg <= od_reg;
            end
            gdsd_pkg::CMD_RES_ERR: begin
                res_y_reg   <= sy_reg;
                res_m_reg   <= sm_reg;
                res_d_reg   <= sd_reg;
                res_cnt_reg <= '0;
                res_st_reg  <= gdsd_pkg::ST_BAD_DATE;
            end
            gdsd_pkg::CMD_RES_SAT: begin
                // clamp to the first or last representable date
                if (n_reg[gdsd_pkg::NUM_W-1]) begin
                    res_y_reg <= gdsd_pkg::YEAR_W'(1);
                    res_m_reg <= gdsd_pkg::MONTH_W'(1);
                    res_d_reg <= gdsd_pkg::DAY_W'(1);
                end else begin
                    res_y_reg <= gdsd_pkg::YEAR_MAX;
                    res_m_reg <= gdsd_pkg::MONTH_MAX;
                    res_d_reg <= gdsd_pkg::DAY_MAX;
                end
                res_cnt_reg <= '0;
                res_st_reg  <= gdsd_pkg::ST_RANGE;
            end
            gdsd_pkg::CMD_RES_STEP: begin
                res_y_reg   <= cur_y_reg;
                res_m_reg   <= cur_m_reg;
                res_d_reg   <= n_reg[gdsd_pkg::DAY_W-1:0] + gdsd_pkg::DAY_W'(1);
                res_cnt_reg <= '0;
                res_st_reg  <= gdsd_pkg::ST_OK;
            end
            gdsd_pkg::CMD_RES_DIFF: begin
                res_y_reg   <= sy_reg;
                res_m_reg   <= sm_reg;
                res_d_reg   <= sd_reg;
                res_cnt_reg <= (a_reg > n_low) ? a_reg - n_low : n_low - a_reg;
                res_st_reg  <= gdsd_pkg::ST_OK;
            end
            gdsd_pkg::CMD_OUT_LOAD: begin
                out_y_reg   <= res_y_reg;
                out_m_reg   <= res_m_reg;
                out_d_reg   <= res_d_reg;
                out_cnt_reg <= res_cnt_reg;
                out_st_reg  <= res_st_reg;
            end
            default: begin
            end
        endcase
    end

    // Result item packing
    assign m_tdata = {{(gdsd_pkg::M_TDATA_W - gdsd_pkg::CNT_LSB - gdsd_pkg::COUNT_W){1'b0}},
                      out_cnt_reg, out_d_reg, out_m_reg, out_y_reg};
    assign m_tuser = out_st_reg;

endmodule

FILE: sv/gdsd_ctrl.sv
// Controller: sequencing state machine and stream handshakes.
module gdsd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  gdsd_pkg::dp_status_t sts,
    output gdsd_pkg::cmd_t       cmd
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_LEAP_Q    = 18'h00002,
        S_LEAP_F    = 18'h00004,
        S_CHECK     = 18'h00008,
        S_DBY_Q     = 18'h00010,
        S_DBY_S     = 18'h00020,
        S_DATE_S    = 18'h00040,
        S_NEXT_DATE = 18'h00080,
        S_DIFF      = 18'h00100,
        S_ADD       = 18'h00200,
        S_RANGE     = 18'h00400,
        S_SRCH_Q    = 18'h00800,
        S_SRCH_C    = 18'h01000,
        S_MSET      = 18'h02000,
        S_WLEAP_Q   = 18'h04000,
        S_WLEAP_F   = 18'h08000,
        S_WALK      = 18'h10000,
        S_DONE      = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    // Next state and datapath command
    always_comb begin
        state_next   = state_reg;
        second_next  = second_reg;
        m_valid_next = m_tready ? 1'b0 : m_valid_reg;
        cmd          = gdsd_pkg::CMD_NOP;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd         = gdsd_pkg::CMD_LOAD;
                    second_next = 1'b0;
                    state_next  = S_LEAP_Q;
                end
            end
            S_LEAP_Q: begin
                cmd        = gdsd_pkg::CMD_LEAP_Q;
                state_next = S_LEAP_F;
            end
            S_LEAP_F: begin
                cmd        = gdsd_pkg::CMD_LEAP_F;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.date_ok) begin
                    state_next = S_DBY_Q;
                end else begin
                    cmd        = gdsd_pkg::CMD_RES_ERR;
                    state_next = S_DONE;
                end
            end
            S_DBY_Q: begin
                cmd        = gdsd_pkg::CMD_DBY_Q;
                state_next = S_DBY_S;
            end
            S_DBY_S: begin
                cmd        = gdsd_pkg::CMD_DBY_S;
                state_next = S_DATE_S;
            end
            S_DATE_S: begin
                cmd = gdsd_pkg::CMD_DATE_S;
                if (!sts.op) begin
                    state_next = S_ADD;
                end else if (second_reg) begin
                    state_next = S_DIFF;
                end else begin
                    state_next = S_NEXT_DATE;
                end
            end
            S_NEXT_DATE: begin
                cmd         = gdsd_pkg::CMD_SAVE_A;
                second_next = 1'b1;
                state_next  = S_LEAP_Q;
            end
            S_DIFF: begin
                cmd        = gdsd_pkg::CMD_RES_DIFF;
                state_next = S_DONE;
            end
            S_ADD: begin
                cmd        = gdsd_pkg::CMD_ADD_OFF;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                if (sts.out_of_range) begin
                    cmd        = gdsd_pkg::CMD_RES_SAT;
                    state_next = S_DONE;
                end else begin
                    cmd        = gdsd_pkg::CMD_SRCH_INIT;
                    state_next = S_SRCH_Q;
                end
            end
            S_SRCH_Q: begin
                cmd        = gdsd_pkg::CMD_SRCH_Q;
                state_next = S_SRCH_C;
            end
            S_SRCH_C: begin
                cmd        = gdsd_pkg::CMD_SRCH_C;
                state_next = sts.last_bit ? S_MSET : S_SRCH_Q;
            end
            S_MSET: begin
                cmd        = gdsd_pkg::CMD_MSET;
                state_next = S_WLEAP_Q;
            end
            S_WLEAP_Q: begin
                cmd        = gdsd_pkg::CMD_LEAP_Q;
                state_next = S_WLEAP_F;
            end
            S_WLEAP_F: begin
                cmd        = gdsd_pkg::CMD_LEAP_F;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (sts.walk_done) begin
                    cmd        = gdsd_pkg::CMD_RES_STEP;
                    state_next = S_DONE;
                end else begin
                    cmd = gdsd_pkg::CMD_WALK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd          = gdsd_pkg::CMD_OUT_LOAD;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register is only overwritten once its item has gone
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == gdsd_pkg::CMD_OUT_LOAD) |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    // An accepted item starts with the leap test of the start date
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_LEAP_Q))
        else $error("accepted item did not start processing");

    // The difference is only taken after both dates are converted
    a_diff_second: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIFF) |-> (second_reg && sts.op))
        else $error("difference taken before second date");

    // A result appears only out of the done state
    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result valid raised outside done state");

endmodule

FILE: sv/gregorian_date_step_and_diff_top.sv
// Top level of the Gregorian date stepper and day counter.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: dates and offset, s_tuser: operation
//  m_      | out       | m_tvalid/m_tready  | m_tdata: result date and count, m_tuser: status
//
// One item at a time. An invalid start date ends at its date check, an invalid second
// date at its own check, a day count after two date conversions, and a step after the
// 14-bit year search (a query and a compare state per bit through the shared divide-by-100
// multiplier) and the month walk; a step that saturates skips the search and the walk.
// Reset is synchronous, active low, and clears the controller and output valid.
// A waiting result is held while the next item is accepted and computed;
// the new result waits in its staging register until m_tready frees the output.
module gregorian_date_step_and_diff_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gdsd_pkg::S_TDATA_W-1:0] s_tdata,  // start_year, start_month, start_day,
                                                     // offset_days, other_year, other_month,
                                                     // other_day, zero pad
    input  logic [gdsd_pkg::S_TUSER_W-1:0] s_tuser,  // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gdsd_pkg::M_TDATA_W-1:0] m_tdata,  // result_year, result_month, result_day,
                                                     // day_count, zero pad
    output logic [gdsd_pkg::M_TUSER_W-1:0] m_tuser   // status
);

    gdsd_pkg::cmd_t       cmd;
    gdsd_pkg::dp_status_t sts;

    gdsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdsd_dp u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
